/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Build with NO_ASSERTIONS defined to leave every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define ABAM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The property must never hold at a rising edge outside reset.
`define ABAM_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ABAM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ABAM_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

/* hw/rtl/abam_pkg.sv */
`default_nettype none

package abam_pkg;

    localparam int X_BITS = 32;
    localparam int Y_BITS = 32;
    localparam int VEC_W  = 32;
    localparam int ROW_W  = (Y_BITS > 1) ? $clog2(Y_BITS) : 1;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(Y_BITS - 1);

    typedef enum logic [1:0] {
        KIND_LEARN  = 2'd0,
        KIND_RECALL = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    typedef logic [1:0] cell_t;
    typedef cell_t [X_BITS-1:0] row_t;

    localparam cell_t CELL_LOW  = 2'd0;
    localparam cell_t CELL_MID  = 2'd1;
    localparam cell_t CELL_HIGH = 2'd2;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             learn;
        logic             first;
    } dp_cmd_t;

    function automatic cell_t alpha_cell(input logic ybit, input logic xbit);
        cell_t res;
        if (ybit == xbit)
            res = CELL_MID;
        else if (ybit)
            res = CELL_HIGH;
        else
            res = CELL_LOW;
        return res;
    endfunction

    function automatic logic beta_cell(input cell_t cval, input logic xbit);
        logic res;
        case (cval)
            CELL_HIGH: res = 1'b1;
            CELL_MID:  res = xbit;
            default:   res = 1'b0;
        endcase
        return res;
    endfunction

    // The first pair after a clear is stored as it stands.
    function automatic cell_t merge_cell(input cell_t a, input cell_t c,
                                         input logic first, input logic mode);
        cell_t res;
        if (first)
            res = a;
        else if (mode == MODE_MAX)
            res = (a > c) ? a : c;
        else
            res = (a < c) ? a : c;
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/abam_ctrl.sv */
`default_nettype none

module abam_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          kind,
    output logic                     busy,
    output logic                     done,
    output logic                     valid_res,
    output abam_pkg::dp_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    state_t                     state_reg, state_next;
    logic [abam_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       learn_reg, learn_next;
    logic                       has_pairs_reg, has_pairs_next;
    logic                       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        learn_next     = learn_reg;
        has_pairs_next = has_pairs_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next = '0;
                    case (abam_pkg::kind_t'(kind))
                        abam_pkg::KIND_LEARN:
                        begin
                            learn_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        abam_pkg::KIND_RECALL:
                        begin
                            learn_next = 1'b0;
                            // Without a stored pair the answer is known at once.
                            state_next = has_pairs_reg ? ST_SWEEP : ST_REPORT;
                        end
                        abam_pkg::KIND_CLEAR:
                        begin
                            has_pairs_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (row_reg == abam_pkg::LAST_ROW)
                    state_next = ST_DRAIN;
                else
                    row_next = row_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (learn_reg)
                begin
                    has_pairs_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            learn_reg     <= 1'b0;
            has_pairs_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            learn_reg     <= learn_next;
            has_pairs_reg <= has_pairs_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_REPORT);
    assign valid_res  = has_pairs_reg;

    assign cmd.load   = accept;
    assign cmd.rd_en  = (state_reg == ST_SWEEP);
    assign cmd.rd_row = row_reg;
    assign cmd.learn  = learn_reg;
    assign cmd.first  = !has_pairs_reg;

`include "assert_macros.svh"

    `ABAM_ASSERT(a_done_returns_idle, clk, rst_n, done |=> !busy,
                 "result strobe not followed by idle")
    `ABAM_ASSERT(a_pairs_set_by_learn, clk, rst_n,
                 $rose(has_pairs_reg) |-> $past(state_reg == ST_DRAIN && learn_reg),
                 "stored-pair flag set outside the end of a learn sweep")
    `ABAM_ASSERT_NEVER(a_learn_no_report, clk, rst_n, done && learn_reg,
                       "learn request produced a result")

endmodule

`default_nettype wire

/* hw/rtl/abam_datapath.sv */
`default_nettype none

module abam_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire abam_pkg::dp_cmd_t                  cmd,
    input  wire logic [abam_pkg::VEC_W-1:0]         x_vec,
    input  wire logic [abam_pkg::VEC_W-1:0]         y_vec,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_wdata,
    output logic [abam_pkg::VEC_W-1:0]              recalled
);

    abam_pkg::row_t             mem [abam_pkg::Y_BITS];
    abam_pkg::row_t             rd_data_reg;
    abam_pkg::row_t             new_row;

    logic [abam_pkg::X_BITS-1:0] x_ext;
    logic [abam_pkg::Y_BITS-1:0] y_ext;
    logic [abam_pkg::X_BITS-1:0] x_reg;
    logic [abam_pkg::Y_BITS-1:0] y_reg;
    logic [abam_pkg::Y_BITS-1:0] res_reg;
    logic [abam_pkg::X_BITS-1:0] beta_bits;

    logic                       mode_reg;
    logic                       proc_en_reg;
    logic [abam_pkg::ROW_W-1:0] proc_row_reg;
    logic                       row_bit;
    logic                       wr_en;

    // Components beyond the port width read as zero.
    for (genvar j = 0; j < abam_pkg::X_BITS; j++)
    begin : g_x_ext
        if (j < abam_pkg::VEC_W)
        begin : g_in
            assign x_ext[j] = x_vec[j];
        end
        else
        begin : g_zero
            assign x_ext[j] = 1'b0;
        end
    end

    for (genvar i = 0; i < abam_pkg::Y_BITS; i++)
    begin : g_y_ext
        if (i < abam_pkg::VEC_W)
        begin : g_in
            assign y_ext[i] = y_vec[i];
        end
        else
        begin : g_zero
            assign y_ext[i] = 1'b0;
        end
    end

    for (genvar k = 0; k < abam_pkg::VEC_W; k++)
    begin : g_out
        if (k < abam_pkg::Y_BITS)
        begin : g_row
            assign recalled[k] = res_reg[k];
        end
        else
        begin : g_zero
            assign recalled[k] = 1'b0;
        end
    end

    // One row is processed the cycle after it was read.
    always_comb
    begin
        for (int j = 0; j < abam_pkg::X_BITS; j++)
        begin
            new_row[j] = abam_pkg::merge_cell(
                abam_pkg::alpha_cell(y_reg[proc_row_reg], x_reg[j]),
                rd_data_reg[j], cmd.first, mode_reg);
            beta_bits[j] = abam_pkg::beta_cell(rd_data_reg[j], x_reg[j]);
        end
        if (mode_reg == abam_pkg::MODE_MAX)
            row_bit = &beta_bits;
        else
            row_bit = |beta_bits;
    end

    assign wr_en = proc_en_reg && cmd.learn;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[proc_row_reg] <= new_row;
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_row];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= x_ext;
            y_reg   <= y_ext;
            res_reg <= '0;
        end
        else if (proc_en_reg && !cmd.learn)
        begin
            res_reg[proc_row_reg] <= row_bit;
        end
        proc_row_reg <= cmd.rd_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= abam_pkg::MODE_MAX;
            proc_en_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            proc_en_reg <= cmd.rd_en;
        end
    end

`include "assert_macros.svh"

    `ABAM_ASSERT(a_last_row_ends, clk, rst_n,
                 (proc_en_reg && proc_row_reg == abam_pkg::LAST_ROW) |=> !proc_en_reg,
                 "row processing continued past the last row")
    `ABAM_ASSERT_NEVER(a_load_during_sweep, clk, rst_n, cmd.load && (cmd.rd_en || proc_en_reg),
                       "new request loaded while a sweep is in flight")

endmodule

`default_nettype wire

/* hw/rtl/alpha_beta_associative_memory.sv */
// Channel  | Signals                              | Handshake
// request  | kind, x_vec, y_vec                   | start high while busy low
// result   | recalled, valid_res                  | done high for one cycle
// config   | cfg_wdata (memory mode)              | cfg_we high, no wait
//
// A learn or recall request sweeps the matrix one row per cycle through the single read
// port of the cell memory, then processes the last row; a recall before any learning
// answers in the cycle after acceptance.
// Clear and unused kinds leave the controller idle and give no result.
// busy is high from acceptance until the request is finished; done is not held off.
// Reset clears the controller and the memory mode; the cells need no clearing pass.
`default_nettype none

module alpha_beta_associative_memory (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 kind,
    input  wire logic [abam_pkg::VEC_W-1:0] x_vec,
    input  wire logic [abam_pkg::VEC_W-1:0] y_vec,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_wdata,
    output logic                            done,
    output logic [abam_pkg::VEC_W-1:0]      recalled,
    output logic                            valid_res
);

    abam_pkg::dp_cmd_t cmd;

    abam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .busy      (busy),
        .done      (done),
        .valid_res (valid_res),
        .cmd       (cmd)
    );

    abam_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .x_vec     (x_vec),
        .y_vec     (y_vec),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .recalled  (recalled)
    );

endmodule

`default_nettype wire
